// File: src/hsb_pkg.sv
`timescale 1ns / 1ps

package hsb_pkg;

   // field widths
   localparam int HUE_W   = 9;
   localparam int PCT_W   = 7;
   localparam int LEVEL_W = 12;

   // scaling constants
   localparam int FULL_SCALE = 4095;
   localparam int HUE_WRAP   = 360;
   localparam int SECT_SPAN  = 60;
   localparam int PCT_MAX    = 100;
   localparam int SAT_HALF   = 50;
   localparam int BRT_NUM    = 6000;   // b/100 over the common denominator 600000

   // intermediate widths
   localparam int CHROMA_W = 14;       // chroma over 60, at most 10000
   localparam int FRAC_W   = 6;        // 0..60
   localparam int NUM_W    = 20;       // numerators over 600000, at most 600000
   localparam int WPROD_W  = 14;       // white factor times brightness, at most 10000

   // level = floor(num * 4095 / 600000) = floor(((num * 4095) >> 6) / 9375)
   localparam int LVL_SHIFT = 6;
   localparam int LVL_V_W   = 26;      // (600000 * 4095) >> 6 fits in 26 bits
   localparam int LVL_RCP_W = 27;
   localparam int LVL_RCP_K = 40;      // 26 bits of dividend + 14 bits of divisor
   localparam logic [LVL_RCP_W-1:0] LVL_RCP = 27'd117281241;  // ceil(2^40 / 9375)

   // white = floor(k * b * 4095 / 10000) = floor(((k * b * 4095) >> 4) / 625)
   localparam int WHT_SHIFT = 4;
   localparam int WHT_V_W   = 22;
   localparam int WHT_RCP_W = 23;
   localparam int WHT_RCP_K = 32;      // 22 bits of dividend + 10 bits of divisor
   localparam logic [WHT_RCP_W-1:0] WHT_RCP = 23'd6871948;    // ceil(2^32 / 625)

   // hue sectors, 60 degrees each
   localparam logic [2:0] SECT_RY = 3'd0;
   localparam logic [2:0] SECT_YG = 3'd1;
   localparam logic [2:0] SECT_GC = 3'd2;
   localparam logic [2:0] SECT_CB = 3'd3;
   localparam logic [2:0] SECT_BM = 3'd4;
   localparam logic [2:0] SECT_MR = 3'd5;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] saturation;
      logic [PCT_W-1:0] brightness;
   } hsb_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
      logic [LEVEL_W-1:0] white_level;
   } hsb_rsp_type;

   typedef struct packed {
      logic [2:0]          sector;
      logic [FRAC_W-1:0]   xf;
      logic [CHROMA_W-1:0] chroma;
      logic [PCT_W-1:0]    brightness;
      logic [PCT_W-1:0]    white_k;
   } hsb_prep_type;

   typedef struct packed {
      logic [2:0]         sector;
      logic [LVL_V_W-1:0] v_hi;
      logic [LVL_V_W-1:0] v_mid;
      logic [LVL_V_W-1:0] v_lo;
      logic [WHT_V_W-1:0] v_white;
   } hsb_mix_type;

endpackage

// File: src/hsb_prep.sv
`timescale 1ns / 1ps

module hsb_prep import hsb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  hsb_req_type  in_data,
   input  logic         white_mode,
   output logic         prep_valid,
   output hsb_prep_type prep_data
);

   logic             a_valid_ff, a_valid_in;
   logic [HUE_W-1:0] a_hue_ff, a_hue_in;
   logic [PCT_W-1:0] a_sat_ff, a_sat_in;
   logic [PCT_W-1:0] a_brt_ff, a_brt_in;
   logic             a_mode_ff, a_mode_in;

   logic             b_valid_ff, b_valid_in;
   hsb_prep_type     b_data_ff, b_data_in;

   logic [HUE_W-1:0]    base;
   logic [HUE_W-1:0]    frac_wide;
   logic [FRAC_W-1:0]   frac;
   logic [CHROMA_W-1:0] sat_brt;

   // stage a: wrap hue, clamp percentages
   always_comb begin
      a_valid_in = in_valid;
      a_hue_in   = (in_data.hue >= HUE_W'(HUE_WRAP)) ? in_data.hue - HUE_W'(HUE_WRAP)
                                                    : in_data.hue;
      a_sat_in   = (in_data.saturation > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                          : in_data.saturation;
      a_brt_in   = (in_data.brightness > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX)
                                                          : in_data.brightness;
      a_mode_in  = white_mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_hue_ff  <= a_hue_in;
      a_sat_ff  <= a_sat_in;
      a_brt_ff  <= a_brt_in;
      a_mode_ff <= a_mode_in;
   end

   // stage b: sector search, ramp value, chroma over 60, white factor
   always_comb begin
      b_data_in = '0;
      priority if (a_hue_ff < HUE_W'(SECT_SPAN)) begin
         b_data_in.sector = SECT_RY;
         base = '0;
      end else if (a_hue_ff < HUE_W'(2 * SECT_SPAN)) begin
         b_data_in.sector = SECT_YG;
         base = HUE_W'(SECT_SPAN);
      end else if (a_hue_ff < HUE_W'(3 * SECT_SPAN)) begin
         b_data_in.sector = SECT_GC;
         base = HUE_W'(2 * SECT_SPAN);
      end else if (a_hue_ff < HUE_W'(4 * SECT_SPAN)) begin
         b_data_in.sector = SECT_CB;
         base = HUE_W'(3 * SECT_SPAN);
      end else if (a_hue_ff < HUE_W'(5 * SECT_SPAN)) begin
         b_data_in.sector = SECT_BM;
         base = HUE_W'(4 * SECT_SPAN);
      end else begin
         b_data_in.sector = SECT_MR;
         base = HUE_W'(5 * SECT_SPAN);
      end
      frac_wide = a_hue_ff - base;
      frac      = frac_wide[FRAC_W-1:0];
      // falling ramp in odd sectors
      b_data_in.xf = b_data_in.sector[0] ? FRAC_W'(SECT_SPAN) - frac : frac;

      sat_brt = CHROMA_W'(a_sat_ff) * CHROMA_W'(a_brt_ff);
      if (a_mode_ff) begin
         if (a_sat_ff > PCT_W'(SAT_HALF)) begin
            b_data_in.chroma = CHROMA_W'(a_brt_ff) * CHROMA_W'(PCT_MAX);
         end else begin
            b_data_in.chroma = {sat_brt[CHROMA_W-2:0], 1'b0};
         end
         // min(200 - 2s, 100)
         if (a_sat_ff < PCT_W'(SAT_HALF)) begin
            b_data_in.white_k = PCT_W'(PCT_MAX);
         end else begin
            b_data_in.white_k = PCT_W'(2 * PCT_MAX) - {a_sat_ff[PCT_W-2:0], 1'b0};
         end
      end else begin
         b_data_in.chroma  = sat_brt;
         b_data_in.white_k = '0;
      end
      b_data_in.brightness = a_brt_ff;
      b_valid_in = a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
      b_data_ff <= b_data_in;
   end

   assign prep_valid = b_valid_ff;
   assign prep_data  = b_data_ff;

endmodule

// File: src/hsb_mix.sv
`timescale 1ns / 1ps

module hsb_mix import hsb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         prep_valid,
   input  hsb_prep_type prep_data,
   output logic         mix_valid,
   output hsb_mix_type  mix_data
);

   logic               c_valid_ff, c_valid_in;
   logic [2:0]         c_sector_ff, c_sector_in;
   logic [NUM_W-1:0]   c_hi_ff, c_hi_in;
   logic [NUM_W-1:0]   c_mid_ff, c_mid_in;
   logic [NUM_W-1:0]   c_lo_ff, c_lo_in;
   logic [WPROD_W-1:0] c_wprod_ff, c_wprod_in;

   logic               d_valid_ff, d_valid_in;
   hsb_mix_type        d_data_ff, d_data_in;

   logic [NUM_W-1:0]   x_num;
   logic [NUM_W-1:0]   c_num;
   logic [NUM_W-1:0]   m_num;

   localparam int P_W  = NUM_W + LEVEL_W;
   localparam int PW_W = WPROD_W + LEVEL_W;

   logic [P_W-1:0]  p_hi, p_mid, p_lo;
   logic [PW_W-1:0] p_white;

   // stage c: numerators over the common denominator
   always_comb begin
      x_num       = NUM_W'(prep_data.chroma) * NUM_W'(prep_data.xf);
      c_num       = NUM_W'(prep_data.chroma) * NUM_W'(SECT_SPAN);
      c_hi_in     = NUM_W'(prep_data.brightness) * NUM_W'(BRT_NUM);
      m_num       = c_hi_in - c_num;
      c_mid_in    = x_num + m_num;
      c_lo_in     = m_num;
      c_wprod_in  = WPROD_W'(prep_data.white_k) * WPROD_W'(prep_data.brightness);
      c_sector_in = prep_data.sector;
      c_valid_in  = prep_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
      c_sector_ff <= c_sector_in;
      c_hi_ff     <= c_hi_in;
      c_mid_ff    <= c_mid_in;
      c_lo_ff     <= c_lo_in;
      c_wprod_ff  <= c_wprod_in;
   end

   // stage d: times full scale, drop the power-of-two part of the divisor
   always_comb begin
      p_hi    = P_W'(c_hi_ff) * P_W'(FULL_SCALE);
      p_mid   = P_W'(c_mid_ff) * P_W'(FULL_SCALE);
      p_lo    = P_W'(c_lo_ff) * P_W'(FULL_SCALE);
      p_white = PW_W'(c_wprod_ff) * PW_W'(FULL_SCALE);
      d_data_in.sector  = c_sector_ff;
      d_data_in.v_hi    = p_hi[LVL_SHIFT +: LVL_V_W];
      d_data_in.v_mid   = p_mid[LVL_SHIFT +: LVL_V_W];
      d_data_in.v_lo    = p_lo[LVL_SHIFT +: LVL_V_W];
      d_data_in.v_white = p_white[WHT_SHIFT +: WHT_V_W];
      d_valid_in        = c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
      end
      d_data_ff <= d_data_in;
   end

   assign mix_valid = d_valid_ff;
   assign mix_data  = d_data_ff;

endmodule

// File: src/hsb_scale.sv
`timescale 1ns / 1ps

module hsb_scale import hsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        mix_valid,
   input  hsb_mix_type mix_data,
   output logic        out_valid,
   output hsb_rsp_type out_data
);

   localparam int LP_W = LVL_V_W + LVL_RCP_W;
   localparam int WP_W = WHT_V_W + WHT_RCP_W;

   logic               e_valid_ff, e_valid_in;
   hsb_rsp_type        e_data_ff, e_data_in;

   logic [LP_W-1:0]    q_hi_p, q_mid_p, q_lo_p;
   logic [WP_W-1:0]    q_white_p;
   logic [LEVEL_W-1:0] hi, mid, lo;

   // stage e: divide by reciprocal, place levels by sector
   always_comb begin
      q_hi_p    = LP_W'(mix_data.v_hi) * LP_W'(LVL_RCP);
      q_mid_p   = LP_W'(mix_data.v_mid) * LP_W'(LVL_RCP);
      q_lo_p    = LP_W'(mix_data.v_lo) * LP_W'(LVL_RCP);
      q_white_p = WP_W'(mix_data.v_white) * WP_W'(WHT_RCP);
      hi  = q_hi_p[LVL_RCP_K +: LEVEL_W];
      mid = q_mid_p[LVL_RCP_K +: LEVEL_W];
      lo  = q_lo_p[LVL_RCP_K +: LEVEL_W];
      e_data_in.white_level = q_white_p[WHT_RCP_K +: LEVEL_W];
      unique case (mix_data.sector)
         SECT_RY: begin
            e_data_in.red_level = hi;  e_data_in.green_level = mid; e_data_in.blue_level = lo;
         end
         SECT_YG: begin
            e_data_in.red_level = mid; e_data_in.green_level = hi;  e_data_in.blue_level = lo;
         end
         SECT_GC: begin
            e_data_in.red_level = lo;  e_data_in.green_level = hi;  e_data_in.blue_level = mid;
         end
         SECT_CB: begin
            e_data_in.red_level = lo;  e_data_in.green_level = mid; e_data_in.blue_level = hi;
         end
         SECT_BM: begin
            e_data_in.red_level = mid; e_data_in.green_level = lo;  e_data_in.blue_level = hi;
         end
         default: begin
            e_data_in.red_level = hi;  e_data_in.green_level = lo;  e_data_in.blue_level = mid;
         end
      endcase
      e_valid_in = mix_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
      end
      e_data_ff <= e_data_in;
   end

   assign out_valid = e_valid_ff;
   assign out_data  = e_data_ff;

endmodule

// File: src/hsb_to_rgbw_pwm_levels.sv
`timescale 1ns / 1ps

// channel    direction  handshake             payload
// request    in         start, busy           req_data (hue, saturation, brightness)
// response   out        rsp_valid strobe      rsp_data (red, green, blue, white levels)
// csr        in         csr_write_enable      csr_write_data (white channel mode)
//
// five-stage pipeline: one request per clock, the response strobes out of stage e
// busy stays low, so start is taken on every cycle it is high
// the response is shown for one cycle only; the receiver cannot stall it
// synchronous reset clears the stage valid bits and sets plain rgb mode
// the mode is sampled as a request enters the first stage

module hsb_to_rgbw_pwm_levels import hsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  hsb_req_type req_data,
   output logic        rsp_valid,
   output hsb_rsp_type rsp_data,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic         mode_ff, mode_in;
   logic         prep_valid;
   hsb_prep_type prep_data;
   logic         mix_valid;
   hsb_mix_type  mix_data;

   // mode register
   always_comb begin
      mode_in = csr_write_enable ? csr_write_data : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // pipeline never holds off a request
   assign busy = 1'b0;

   hsb_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start),
      .in_data    (req_data),
      .white_mode (mode_ff),
      .prep_valid (prep_valid),
      .prep_data  (prep_data)
   );

   hsb_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .prep_valid (prep_valid),
      .prep_data  (prep_data),
      .mix_valid  (mix_valid),
      .mix_data   (mix_data)
   );

   hsb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .mix_valid (mix_valid),
      .mix_data  (mix_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
